/* rtl/core/adsr_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the
// ADSR cutoff envelope. No dependencies.
`default_nettype none

package adsr_pkg;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned DIV_STEPS  = 16;

    // event kinds
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

    // envelope stages
    localparam logic [2:0] STG_IDLE    = 3'd0;
    localparam logic [2:0] STG_ATTACK  = 3'd1;
    localparam logic [2:0] STG_DECAY   = 3'd2;
    localparam logic [2:0] STG_SUSTAIN = 3'd3;
    localparam logic [2:0] STG_RELEASE = 3'd4;

    // register indexes
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_BASE    = 3'd4;
    localparam logic [2:0] REG_AMOUNT  = 3'd5;

    localparam logic [15:0] LEVEL_ONE   = 16'h8000;
    localparam logic [14:0] CUT_MIN     = 15'd20;
    localparam logic [14:0] CUT_MAX     = 15'd20000;
    localparam logic [12:0] ENV_SPAN_HZ = 13'd8000;

    typedef struct packed {
        logic capture;
        logic eval;
        logic mul;
        logic div_step;
        logic set_level;
        logic cm1;
        logic cm2;
        logic cut;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic need_div;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/core/adsr_ctrl.sv */
// Sequencer for the envelope: one event at a time through evaluate,
// ramp divide, cutoff multiply and output load. Uses adsr_pkg.
`default_nettype none

module adsr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  adsr_pkg::sts_t     sts,
    output adsr_pkg::cmd_t     cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EVAL = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_DIV  = 9'b000001000,
        S_LVL  = 9'b000010000,
        S_CM1  = 9'b000100000,
        S_CM2  = 9'b001000000,
        S_CUT  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!sts.is_tick)
                    state_next = S_DONE;
                else if (sts.need_div)
                    state_next = S_MUL;
                else
                    state_next = S_CM1;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'(adsr_pkg::DIV_STEPS - 1))
                    state_next = S_LVL;
            end
            S_LVL:
            begin
                cmd.set_level = 1'b1;
                state_next    = S_CM1;
            end
            S_CM1:
            begin
                cmd.cm1    = 1'b1;
                state_next = S_CM2;
            end
            S_CM2:
            begin
                cmd.cm2    = 1'b1;
                state_next = S_CUT;
            end
            S_CUT:
            begin
                cmd.cut    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load_out)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adsr_dp.sv */
// Datapath: settings, envelope state, ramp multiplier, restoring divider,
// cutoff scaling and the output register. Uses adsr_pkg.
`default_nettype none

module adsr_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [1:0]                        in_mode,
    input  wire logic [15:0]                       in_dt,
    input  adsr_pkg::cmd_t                         cmd,
    output adsr_pkg::sts_t                         sts,
    output logic [14:0]                            out_cutoff,
    output logic [15:0]                            out_level,
    output logic [2:0]                             out_stage
);

    logic [15:0] attack_reg, decay_reg, sustain_reg, release_reg, amount_reg;
    logic [14:0] base_reg;

    logic [2:0]  stage_reg;
    logic [31:0] time_reg;
    logic [15:0] level_reg;
    logic [14:0] cutoff_reg;

    logic [1:0]  mode_reg;
    logic [15:0] dt_reg;
    logic [15:0] mul_a_reg, mul_b_reg, div_reg;
    logic        decay_ramp_reg;
    logic [15:0] rem_reg, quo_reg;
    logic [31:0] prod1_reg;
    logic [44:0] prod2_reg;
    logic [14:0] out_cutoff_reg;
    logic [15:0] out_level_reg;
    logic [2:0]  out_stage_reg;

    logic [32:0] sum;
    logic [31:0] t_sat;
    logic [15:0] s_q;
    logic [2:0]  stage_n;
    logic [31:0] time_n;
    logic [15:0] level_n;
    logic [15:0] mul_a_n, mul_b_n, div_n;
    logic        decay_n;
    logic        need_div;
    logic        is_tick;
    logic [31:0] prod;
    logic [16:0] part, trial;
    logic        take;
    logic [18:0] hz;
    logic [14:0] hz_clamped;

    assign sum     = {1'b0, time_reg} + {17'd0, dt_reg};
    assign t_sat   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign s_q     = (sustain_reg > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE : sustain_reg;
    assign is_tick = (mode_reg == adsr_pkg::MODE_TICK) && (dt_reg != 16'd0);

    always_comb
    begin
        stage_n  = stage_reg;
        time_n   = t_sat;
        level_n  = level_reg;
        mul_a_n  = t_sat[15:0];
        mul_b_n  = adsr_pkg::LEVEL_ONE;
        div_n    = attack_reg;
        decay_n  = 1'b0;
        need_div = 1'b0;
        unique case (stage_reg)
            adsr_pkg::STG_ATTACK:
            begin
                if (attack_reg == 16'd0 || t_sat >= {16'd0, attack_reg})
                begin
                    level_n = adsr_pkg::LEVEL_ONE;
                    stage_n = adsr_pkg::STG_DECAY;
                    time_n  = '0;
                end
                else
                    need_div = 1'b1;
            end
            adsr_pkg::STG_DECAY:
            begin
                if (decay_reg == 16'd0 || t_sat >= {16'd0, decay_reg})
                begin
                    level_n = s_q;
                    stage_n = adsr_pkg::STG_SUSTAIN;
                end
                else
                begin
                    need_div = 1'b1;
                    decay_n  = 1'b1;
                    mul_b_n  = adsr_pkg::LEVEL_ONE - s_q;
                    div_n    = decay_reg;
                end
            end
            adsr_pkg::STG_SUSTAIN:
            begin
                level_n = s_q;
            end
            adsr_pkg::STG_RELEASE:
            begin
                if (release_reg == 16'd0 || t_sat >= {16'd0, release_reg})
                begin
                    level_n = '0;
                    stage_n = adsr_pkg::STG_IDLE;
                end
                else
                begin
                    need_div = 1'b1;
                    mul_a_n  = s_q;
                    mul_b_n  = release_reg - t_sat[15:0];
                    div_n    = release_reg;
                end
            end
            default:
            begin
                stage_n = adsr_pkg::STG_IDLE;
                level_n = '0;
            end
        endcase
    end

    assign sts.is_tick  = is_tick;
    assign sts.need_div = need_div;

    // restoring divide, one quotient bit per step
    assign prod  = mul_a_reg * mul_b_reg;
    assign part  = {rem_reg, quo_reg[15]};
    assign take  = part >= {1'b0, div_reg};
    assign trial = part - {1'b0, div_reg};

    assign hz = {4'd0, base_reg} + {1'b0, prod2_reg[44:27]};
    always_comb
    begin
        if (hz < {4'd0, adsr_pkg::CUT_MIN})
            hz_clamped = adsr_pkg::CUT_MIN;
        else if (hz > {4'd0, adsr_pkg::CUT_MAX})
            hz_clamped = adsr_pkg::CUT_MAX;
        else
            hz_clamped = hz[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= 16'd10;
            decay_reg   <= 16'd200;
            sustain_reg <= 16'd16384;
            release_reg <= 16'd400;
            base_reg    <= 15'd800;
            amount_reg  <= 16'd4096;
            stage_reg   <= adsr_pkg::STG_IDLE;
            time_reg    <= '0;
            level_reg   <= '0;
            cutoff_reg  <= adsr_pkg::CUT_MIN;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    adsr_pkg::REG_ATTACK:  attack_reg  <= cfg_data;
                    adsr_pkg::REG_DECAY:   decay_reg   <= cfg_data;
                    adsr_pkg::REG_SUSTAIN: sustain_reg <= cfg_data;
                    adsr_pkg::REG_RELEASE: release_reg <= cfg_data;
                    adsr_pkg::REG_BASE:    base_reg    <= cfg_data[14:0];
                    adsr_pkg::REG_AMOUNT:  amount_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.eval)
            begin
                if (is_tick)
                begin
                    stage_reg <= stage_n;
                    time_reg  <= time_n;
                    level_reg <= level_n;
                end
                else if (mode_reg == adsr_pkg::MODE_NOTE_ON)
                begin
                    stage_reg <= adsr_pkg::STG_ATTACK;
                    time_reg  <= '0;
                    level_reg <= '0;
                end
                else if (mode_reg == adsr_pkg::MODE_NOTE_OFF)
                begin
                    stage_reg <= adsr_pkg::STG_RELEASE;
                    time_reg  <= '0;
                end
            end
            if (cmd.set_level)
                level_reg <= decay_ramp_reg ? adsr_pkg::LEVEL_ONE - quo_reg : quo_reg;
            if (cmd.cut)
                cutoff_reg <= hz_clamped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            dt_reg   <= in_dt;
        end
        if (cmd.eval)
        begin
            mul_a_reg      <= mul_a_n;
            mul_b_reg      <= mul_b_n;
            div_reg        <= div_n;
            decay_ramp_reg <= decay_n;
        end
        if (cmd.mul)
        begin
            rem_reg <= prod[31:16];
            quo_reg <= prod[15:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= take ? trial[15:0] : part[15:0];
            quo_reg <= {quo_reg[14:0], take};
        end
        if (cmd.cm1)
            prod1_reg <= amount_reg * level_reg;
        if (cmd.cm2)
            prod2_reg <= {13'd0, prod1_reg} * {32'd0, adsr_pkg::ENV_SPAN_HZ};
        if (cmd.load_out)
        begin
            out_cutoff_reg <= cutoff_reg;
            out_level_reg  <= level_reg;
            out_stage_reg  <= stage_reg;
        end
    end

    assign out_cutoff = out_cutoff_reg;
    assign out_level  = out_level_reg;
    assign out_stage  = out_stage_reg;

endmodule

`default_nettype wire

/* rtl/core/adsr_filter_envelope_cutoff.sv */
// Top level of the ADSR filter-cutoff envelope: stream ports, register port,
// controller and datapath. Uses adsr_pkg, adsr_ctrl, adsr_dp.
//
// Usage:
//   Events enter on the s_ stream: s_tuser = kind (tick, note on, note off),
//   s_tdata = elapsed milliseconds. Every accepted event gives exactly one
//   result transfer on the m_ stream with the applied cutoff, the envelope
//   level and the stage.
//   Settings are written through cfg_we/cfg_index/cfg_data while idle.
//   Note events and zero ticks go from evaluate straight to the output
//   load; ticks that end a ramp or hold pass through two registered
//   multiplies for the cutoff scaling; ticks inside a ramp first pass the
//   ramp multiply and the 16-step restoring divider for the ramp fraction.
//   One event is in work at a time; s_tready rises the cycle after the
//   result is loaded.
//   The result register frees the sequencer: a new event is accepted while
//   a result still waits; if the receiver stalls, the next result is held
//   back until the previous one is taken.
//   Reset loads the default settings, stage idle, level zero, cutoff 20 Hz.
`default_nettype none

module adsr_filter_envelope_cutoff (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [adsr_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] elapsed_ms
    input  wire logic [adsr_pkg::IN_USER_W-1:0]      s_tuser,   // [1:0] mode
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [14:0] cutoff_hz, [30:15] env_level, [33:31] env_stage, [39:34] zero
    output logic [adsr_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    adsr_pkg::cmd_t cmd;
    adsr_pkg::sts_t sts;
    logic [14:0]    cutoff;
    logic [15:0]    level;
    logic [2:0]     stage;

    adsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    adsr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_mode    (s_tuser),
        .in_dt      (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_cutoff (cutoff),
        .out_level  (level),
        .out_stage  (stage)
    );

    assign m_tdata = {6'd0, stage, level, cutoff};

endmodule

`default_nettype wire

/* rtl/core/adsr_chk.sv */
// Port-level checks for the ADSR cutoff envelope, bound to the top level.
// Uses adsr_pkg.
`default_nettype none

module adsr_chk (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [adsr_pkg::OUT_DATA_W-1:0]     m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second event accepted while one is in work");

    a_cutoff_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:0] >= adsr_pkg::CUT_MIN) &&
                     (m_tdata[14:0] <= adsr_pkg::CUT_MAX))
        else $error("cutoff out of range");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:15] <= adsr_pkg::LEVEL_ONE)
        else $error("level above one");

    a_stage_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:31] == adsr_pkg::STG_IDLE) |-> m_tdata[30:15] == 16'd0)
        else $error("nonzero level in idle stage");

endmodule

bind adsr_filter_envelope_cutoff adsr_chk u_adsr_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
